### hw/rtl/pixel_packetizer_crc8_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel packetizer core
// Clocked concurrent assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef PIXEL_PACKETIZER_CRC8_CORE_MACROS_SVH
`define PIXEL_PACKETIZER_CRC8_CORE_MACROS_SVH

// Check a property at every rising edge outside reset
`define PKT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pixel_packetizer_crc8_core: property violated");

// Check that an implication's consequent holds in the cycle after its antecedent
`define PKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel_packetizer_crc8_core: sequence violated");

`endif

### hw/rtl/pkt_crc8_pkg.sv
// ----------------------------------------------------------------------------
// Pixel packetizer package
// Field widths, the result record and the byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package pkt_crc8_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PKTNUM_W = 10;
	localparam int unsigned POSOUT_W = 6;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// One result transaction
	typedef struct packed {
		logic [BYTE_W-1:0]   sample_byte;
		logic [PKTNUM_W-1:0] packet_number;
		logic [POSOUT_W-1:0] position;
		logic                end_of_packet;
		logic [BYTE_W-1:0]   check_byte;
		logic                end_of_image;
	} frame_t;

	// Advance the reflected CRC-32 register by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc,
	                                         input logic [BYTE_W-1:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/pixel_packetizer_crc8_core.sv
// ----------------------------------------------------------------------------
// Pixel packetizer with truncated CRC-32 packet check
// Keeps the first channel of each pixel, frames samples into numbered packets
// and emits the low CRC-32 byte on the last sample of each packet.
// ----------------------------------------------------------------------------
// Takes one RGBA byte per cycle, sustained, whenever the result side keeps up;
// three of every four bytes (BYTES_PER_PIXEL-1 of BYTES_PER_PIXEL) are dropped
// and only the first channel yields a result transaction. A kept byte reaches
// the output through one input register, then the
// byte-wide CRC update and counter compare, then the result register. A
// stalled result blocks the input only once the input register also holds a
// kept byte. The packet CRC is the zlib CRC-32 over the samples of the packet.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_packetizer_crc8_core #(
	parameter int unsigned PACKET_BYTES    = 64,
	parameter int unsigned PACKET_TOTAL    = 1024,
	parameter int unsigned BYTES_PER_PIXEL = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              raw_valid,
	output logic                                   raw_ready,
	input  wire logic [pkt_crc8_pkg::BYTE_W-1:0]   raw_byte,
	output logic                                   sample_valid,
	input  wire logic                              sample_ready,
	output logic [pkt_crc8_pkg::BYTE_W-1:0]        sample_byte,
	output logic [pkt_crc8_pkg::PKTNUM_W-1:0]      packet_number,
	output logic [pkt_crc8_pkg::POSOUT_W-1:0]      position,
	output logic                                   end_of_packet,
	output logic [pkt_crc8_pkg::BYTE_W-1:0]        check_byte,
	output logic                                   end_of_image
);
	import pkt_crc8_pkg::*;

	logic              vld_s1;
	logic [BYTE_W-1:0] raw_s1;
	logic              out_vld_q;
	frame_t            res_q;

	logic   keep;
	frame_t res_d;
	logic   out_free;
	logic   s1_adv;
	logic   accept;

	pkt_crc8_framer #(
		.PACKET_BYTES    (PACKET_BYTES),
		.PACKET_TOTAL    (PACKET_TOTAL),
		.BYTES_PER_PIXEL (BYTES_PER_PIXEL)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_adv),
		.data    (raw_s1),
		.keep    (keep),
		.res     (res_d)
	);

	// Move the staged byte on: dropped bytes always, kept ones when output is free
	always_comb begin
		out_free  = !out_vld_q || sample_ready;
		s1_adv    = vld_s1 && (!keep || out_free);
		raw_ready = !vld_s1 || s1_adv;
		accept    = raw_valid && raw_ready;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= raw_byte;
		end
	end

	// Result register: load a kept byte, drop the valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv && keep) begin
			out_vld_q <= 1'b1;
		end else if (sample_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && keep) begin
			res_q <= res_d;
		end
	end

	// Drive the result transaction
	assign sample_valid  = out_vld_q;
	assign sample_byte   = res_q.sample_byte;
	assign packet_number = res_q.packet_number;
	assign position      = res_q.position;
	assign end_of_packet = res_q.end_of_packet;
	assign check_byte    = res_q.check_byte;
	assign end_of_image  = res_q.end_of_image;

`include "pixel_packetizer_crc8_core_macros.svh"

	`PKT_ASSERT(a_eoi_in_eop, clk, arst_n, out_vld_q && res_q.end_of_image |-> res_q.end_of_packet)
	`PKT_ASSERT(a_check_zero, clk, arst_n, out_vld_q && !res_q.end_of_packet |-> res_q.check_byte == '0)
	`PKT_ASSERT_NEXT(a_kept_held, clk, arst_n, vld_s1 && keep && !out_free, vld_s1 && keep && raw_s1 == $past(raw_s1))

endmodule

`default_nettype wire

### hw/rtl/pkt_crc8_framer.sv
// ----------------------------------------------------------------------------
// Pixel packetizer framing state
// Tracks channel phase, sample position, packet number and the packet CRC;
// forms the result record for the byte presented and updates on advance.
// ----------------------------------------------------------------------------
`default_nettype none

module pkt_crc8_framer #(
	parameter int unsigned PACKET_BYTES    = 64,
	parameter int unsigned PACKET_TOTAL    = 1024,
	parameter int unsigned BYTES_PER_PIXEL = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           advance,
	input  wire logic [pkt_crc8_pkg::BYTE_W-1:0] data,
	output logic                                keep,
	output pkt_crc8_pkg::frame_t                res
);
	import pkt_crc8_pkg::*;

	localparam int unsigned PH_W  = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;
	localparam int unsigned POS_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
	localparam int unsigned PKT_W = (PACKET_TOTAL > 1) ? $clog2(PACKET_TOTAL) : 1;

	logic [PH_W-1:0]  phase_q;
	logic [POS_W-1:0] pos_q;
	logic [PKT_W-1:0] pkt_q;
	logic [31:0]      crc_q;

	logic [31:0] crc_next;
	logic        eop;
	logic        eoi;
	logic        last_phase;

	// Decode the current byte against the framing state
	always_comb begin
		last_phase = (phase_q == PH_W'(BYTES_PER_PIXEL - 1));
		keep       = (phase_q == '0);
		crc_next   = crc_byte(crc_q, data);
		eop        = (pos_q == POS_W'(PACKET_BYTES - 1));
		eoi        = eop && (pkt_q == PKT_W'(PACKET_TOTAL - 1));

		res.sample_byte   = data;
		res.packet_number = PKTNUM_W'(pkt_q);
		res.position      = POSOUT_W'(pos_q);
		res.end_of_packet = eop;
		res.check_byte    = eop ? ~crc_next[BYTE_W-1:0] : '0;
		res.end_of_image  = eoi;
	end

	// Advance phase on every byte; counters and CRC on kept bytes only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= '0;
			pkt_q   <= '0;
			crc_q   <= CRC_INIT;
		end else if (advance) begin
			phase_q <= last_phase ? '0 : phase_q + 1'b1;
			if (keep) begin
				if (eop) begin
					crc_q <= CRC_INIT;
					pos_q <= '0;
					pkt_q <= eoi ? '0 : pkt_q + 1'b1;
				end else begin
					crc_q <= crc_next;
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### sim/tb_pixel_packetizer_crc8_core.sv
// ----------------------------------------------------------------------------
// Testbench for the pixel packetizer with truncated CRC-32 packet check
// Drives an RGBA byte stream with bursty valid and a receiver that stalls on
// its own pattern. A built-in predictor tracks channel phase, sample position,
// packet number and the per-packet reflected CRC-32, and every result
// transaction is compared field by field in arrival order. Covers a directed
// pixel set, a run of whole packets across packet boundaries, a long receiver
// hold that backs up the input, and a random stream.
// ----------------------------------------------------------------------------
module tb_pixel_packetizer_crc8_core;

	import pkt_crc8_pkg::*;

	localparam int unsigned CLK_PERIOD     = 12;
	localparam int unsigned PKT_SAMPLES    = 64;
	localparam int unsigned PKT_TOTAL      = 1024;
	localparam int unsigned PIX_BYTES      = 4;
	localparam int unsigned RUN_PACKETS    = 2;
	localparam int unsigned RUN_BYTES      = RUN_PACKETS * PKT_SAMPLES * PIX_BYTES;
	localparam int unsigned RANDOM_BYTES   = 320;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned HOLD_BYTES     = 120;
	localparam int unsigned DRAIN_SLACK    = 8;
	localparam int unsigned DRAIN_LIMIT    = 20000;
	localparam int unsigned TIMEOUT_CYCLES = 200000;
	localparam int unsigned MAX_REPORTS    = 40;
	localparam logic [31:0] CRC32_REFL_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC32_SEED      = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		RX_FULL,
		RX_RANDOM,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_e;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                raw_valid     = 1'b0;
	logic [BYTE_W-1:0]   raw_byte      = '0;
	logic                sample_ready  = 1'b0;
	logic                raw_ready;
	logic                sample_valid;
	logic [BYTE_W-1:0]   sample_byte;
	logic [PKTNUM_W-1:0] packet_number;
	logic [POSOUT_W-1:0] position;
	logic                end_of_packet;
	logic [BYTE_W-1:0]   check_byte;
	logic                end_of_image;

	// Receiver control; mode and hold request written by the test tasks with nonblocking assignments
	rx_mode_e    rx_mode   = RX_FULL;
	int unsigned hold_seq  = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned rx_tick   = 0;

	// Predictor state of the packetizer
	int unsigned pred_phase  = 0;
	int unsigned pred_pos    = 0;
	int unsigned pred_pkt    = 0;
	logic [31:0] pred_crc    = CRC32_SEED;
	frame_t      frames_due[$];

	// Run statistics
	int unsigned err_count      = 0;
	int unsigned bytes_taken    = 0;
	int unsigned samples_done   = 0;
	int unsigned packets_done   = 0;
	int unsigned images_done    = 0;
	int unsigned input_stalls   = 0;

	pixel_packetizer_crc8_core #(
		.PACKET_BYTES    (PKT_SAMPLES),
		.PACKET_TOTAL    (PKT_TOTAL),
		.BYTES_PER_PIXEL (PIX_BYTES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.raw_valid     (raw_valid),
		.raw_ready     (raw_ready),
		.raw_byte      (raw_byte),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample_byte   (sample_byte),
		.packet_number (packet_number),
		.position      (position),
		.end_of_packet (end_of_packet),
		.check_byte    (check_byte),
		.end_of_image  (end_of_image)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Advance a reflected CRC-32 one data bit at a time, LSB first
	function automatic logic [31:0] crc32_feed(input logic [31:0] acc,
	                                           input logic [BYTE_W-1:0] d);
		logic fb;
		for (int i = 0; i < BYTE_W; i++) begin
			fb  = acc[0] ^ d[i];
			acc = {1'b0, acc[31:1]};
			if (fb)
				acc = acc ^ CRC32_REFL_POLY;
		end
		return acc;
	endfunction

	// Fold one accepted byte into the predictor; queue a frame for kept bytes
	task automatic absorb_byte(input logic [BYTE_W-1:0] b);
		logic        keep;
		logic        last_in_pkt;
		logic        last_in_img;
		logic [31:0] crc_next;
		frame_t      fr;
		keep       = (pred_phase == 0);
		pred_phase = (pred_phase + 1 >= PIX_BYTES) ? 0 : pred_phase + 1;
		if (keep) begin
			crc_next    = crc32_feed(pred_crc, b);
			last_in_pkt = (pred_pos + 1 >= PKT_SAMPLES);
			last_in_img = last_in_pkt && (pred_pkt + 1 >= PKT_TOTAL);
			fr.sample_byte   = b;
			fr.packet_number = pred_pkt[PKTNUM_W-1:0];
			fr.position      = pred_pos[POSOUT_W-1:0];
			fr.end_of_packet = last_in_pkt;
			fr.check_byte    = last_in_pkt ? ~crc_next[BYTE_W-1:0] : '0;
			fr.end_of_image  = last_in_img;
			frames_due.insert(frames_due.size(), fr);
			if (last_in_pkt) begin
				pred_crc = CRC32_SEED;
				pred_pos = 0;
				pred_pkt = last_in_img ? 0 : pred_pkt + 1;
			end else begin
				pred_crc = crc_next;
				pred_pos = pred_pos + 1;
			end
		end
	endtask

	task automatic check_field(input string fname, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d",
				         $time, fname, want, got);
		end
	endtask

	// Check each result transaction, then predict from each input transaction
	always @(posedge clk) begin
		frame_t want;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				if (frames_due.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: unexpected sample, expected none, got byte %0d",
						         $time, sample_byte);
				end else begin
					want = frames_due.pop_front();
					check_field("sample_byte", 32'(want.sample_byte), 32'(sample_byte));
					check_field("packet_number", 32'(want.packet_number),
					            32'(packet_number));
					check_field("position", 32'(want.position), 32'(position));
					check_field("end_of_packet", 32'(want.end_of_packet),
					            32'(end_of_packet));
					check_field("check_byte", 32'(want.check_byte), 32'(check_byte));
					check_field("end_of_image", 32'(want.end_of_image),
					            32'(end_of_image));
					samples_done++;
					if (want.end_of_packet)
						packets_done++;
					if (want.end_of_image)
						images_done++;
				end
			end
			if (raw_valid && raw_ready) begin
				absorb_byte(raw_byte);
				bytes_taken++;
			end
			if (raw_valid && !raw_ready)
				input_stalls++;
		end
	end

	// Drive the result ready: a requested hold wins, otherwise the current mode
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_seq != hold_seen) begin
			hold_seen    <= hold_seq;
			hold_left    <= HOLD_CYCLES;
			sample_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			sample_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FULL: begin
					sample_ready <= 1'b1;
				end
				RX_RANDOM: begin
					sample_ready <= ($urandom_range(0, 3) != 0);
				end
				RX_PATTERN: begin
					sample_ready <= ((rx_tick % 7) != 3) && ((rx_tick % 13) > 4);
				end
				default: begin
					sample_ready <= ((rx_tick % 8) == 0);
				end
			endcase
		end
	end

	// Offer one byte and hold it until the transaction completes
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		raw_valid <= 1'b1;
		raw_byte  <= b;
		do
			@(posedge clk);
		while (!raw_ready);
	endtask

	task automatic idle_cycles(input int unsigned n);
		if (n != 0) begin
			raw_valid <= 1'b0;
			raw_byte  <= BYTE_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Let every queued frame arrive, then report any that never came
	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		idle_cycles(1);
		while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_SLACK) @(posedge clk);
		if (frames_due.size() != 0) begin
			err_count += frames_due.size();
			$display("%0t: missing samples, expected %0d more, got 0",
			         $time, frames_due.size());
			frames_due.delete();
		end
	endtask

	// Extreme and alternating values on the kept channel, the opposite on the
	// dropped channels so that any leak into the CRC or the sample shows up
	task automatic test_directed();
		logic [BYTE_W-1:0] keep_vals[6];
		keep_vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
		rx_mode <= RX_FULL;
		foreach (keep_vals[i]) begin
			send_byte(keep_vals[i]);
			for (int c = 1; c < PIX_BYTES; c++)
				send_byte(~keep_vals[i]);
		end
		wait_drained();
	endtask

	// Whole packets back to back so the CRC restart and packet count advance
	task automatic test_packet_run();
		rx_mode <= RX_RANDOM;
		for (int unsigned n = 0; n < RUN_BYTES + 4 * PIX_BYTES; n++) begin
			send_byte(BYTE_W'($urandom));
			if ($urandom_range(0, 63) == 0)
				idle_cycles($urandom_range(1, 6));
		end
		wait_drained();
	endtask

	// Hold the receiver off while the sender keeps offering bytes
	task automatic test_backpressure();
		rx_mode  <= RX_FULL;
		hold_seq <= hold_seq + 1;
		for (int unsigned n = 0; n < HOLD_BYTES; n++)
			send_byte(BYTE_W'($urandom));
		wait_drained();
	endtask

	// Random bytes in bursts of random length, receiver mode changed per phase
	task automatic test_random_stream();
		int unsigned sent;
		int unsigned burst;
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			rx_mode <= rx_mode_e'(ph);
			while (sent < (ph + 1) * RANDOM_BYTES / 4) begin
				burst = $urandom_range(1, 40);
				for (int unsigned k = 0; k < burst; k++) begin
					send_byte(BYTE_W'($urandom));
					sent++;
				end
				if ($urandom_range(0, 3) != 0)
					idle_cycles($urandom_range(1, 12));
			end
			wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_packet_run();
		test_backpressure();
		test_random_stream();
		$display("Covered %0d input bytes, %0d samples, %0d packets, %0d image wraps.",
		         bytes_taken, samples_done, packets_done, images_done);
		$display("Input stalled for %0d cycles; %0d field errors.",
		         input_stalls, err_count);
		if (err_count == 0)
			$display("tb_pixel_packetizer_crc8_core OK");
		else
			$display("tb_pixel_packetizer_crc8_core NOT OK");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("%0t: timeout with %0d samples outstanding", $time, frames_due.size());
		$display("tb_pixel_packetizer_crc8_core NOT OK");
		$finish;
	end

endmodule
